// ===== sv/positional_list_engine_top_defines.svh =====
// ----------------------------------------------------------------------------
// positional_list_engine_top_defines
// Assertion macros shared by the list engine modules.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define PLE_ASSERT_IMPL(label, cond, cons, msg) \
  `PLE_ASSERT(label, (cond) |-> (cons), msg)

`endif

// ===== sv/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Widths, command and status codes and the response record of the list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  removed_value;
  } resp_t;

endpackage

// ===== sv/ple_ram.sv =====
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = ple_pkg::DATA_W,
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ple_seq.sv =====
// ----------------------------------------------------------------------------
// ple_seq
// Command check and shift sequencer: moves list entries one at a time
// through the list RAM for positional inserts and deletes.
// ----------------------------------------------------------------------------
`include "positional_list_engine_top_defines.svh"

module ple_seq #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [ple_pkg::CMD_W-1:0]   cmd,
  input  logic [ple_pkg::DATA_W-1:0]  value,
  input  logic [ple_pkg::POS_W-1:0]   position,
  output logic                        resp_valid,
  input  logic                        resp_ready,
  output ple_pkg::resp_t              resp,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [ple_pkg::DATA_W-1:0]  ram_wdata,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  logic [ple_pkg::DATA_W-1:0]  ram_rdata
);

  localparam int PW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_RD,
    S_DEL_CAP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_INS_WR,
    S_RESP
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       ins_r, ins_nxt;
  logic                       op_r, op_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [ple_pkg::DATA_W-1:0] value_r, value_nxt;
  logic [ple_pkg::DATA_W-1:0] removed_r, removed_nxt;
  ple_pkg::status_t           status_r, status_nxt;
  logic [CW-1:0]              count_r, count_nxt;

  logic [PW-1:0]              pos_ext;
  logic [PW-1:0]              cnt_ext;
  logic                       full;
  logic                       empty;
  logic                       dec_ins;
  logic                       dec_op;
  logic [AW-1:0]              dec_idx;
  ple_pkg::status_t           dec_status;
  logic [CW-1:0]              count_new;

  // Command check
  always_comb begin
    pos_ext    = PW'(position);
    cnt_ext    = PW'(count_r);
    full       = (count_r == CW'(DEPTH));
    empty      = (count_r == '0);
    dec_ins    = 1'b0;
    dec_op     = 1'b0;
    dec_idx    = '0;
    dec_status = ple_pkg::ST_OK;
    unique case (ple_pkg::cmd_t'(cmd)) inside
      ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_BACK, ple_pkg::CMD_INS_POS: begin
        dec_ins = 1'b1;
        if (full) begin
          dec_status = ple_pkg::ST_FULL;
        end else if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_INS_FRONT) begin
          dec_op = 1'b1;
        end else if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_INS_BACK) begin
          dec_op  = 1'b1;
          dec_idx = AW'(count_r);
        end else if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1)) begin
          dec_status = ple_pkg::ST_BADPOS;
        end else begin
          dec_op  = 1'b1;
          dec_idx = AW'(pos_ext - PW'(1));
        end
      end
      ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_BACK, ple_pkg::CMD_DEL_POS: begin
        if (empty) begin
          dec_status = ple_pkg::ST_EMPTY;
        end else if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_DEL_FRONT) begin
          dec_op = 1'b1;
        end else if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_DEL_BACK) begin
          dec_op  = 1'b1;
          dec_idx = AW'(count_r - CW'(1));
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          dec_status = ple_pkg::ST_BADPOS;
        end else begin
          dec_op  = 1'b1;
          dec_idx = AW'(pos_ext - PW'(1));
        end
      end
      default: begin
        dec_status = ple_pkg::ST_OK;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    ins_nxt     = ins_r;
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    ptr_nxt     = ptr_r;
    value_nxt   = value_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    count_nxt   = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          ins_nxt     = dec_ins;
          op_nxt      = dec_op;
          idx_nxt     = dec_idx;
          value_nxt   = value;
          removed_nxt = '0;
          status_nxt  = dec_status;
          if (!dec_op) begin
            state_nxt = S_RESP;
          end else if (!dec_ins) begin
            state_nxt = S_DEL_RD;
          end else if (CW'(dec_idx) == count_r) begin
            state_nxt = S_INS_WR;
          end else begin
            ptr_nxt   = AW'(count_r - CW'(1));
            state_nxt = S_MOVE_RD;
          end
        end
      end
      S_DEL_RD: begin
        state_nxt = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        removed_nxt = ram_rdata;
        if (CW'(idx_r) + CW'(1) == count_r) begin
          state_nxt = S_RESP;
        end else begin
          ptr_nxt   = idx_r + AW'(1);
          state_nxt = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        if (ins_r) begin
          if (ptr_r == idx_r) begin
            state_nxt = S_INS_WR;
          end else begin
            ptr_nxt   = ptr_r - AW'(1);
            state_nxt = S_MOVE_RD;
          end
        end else if (CW'(ptr_r) + CW'(1) == count_r) begin
          state_nxt = S_RESP;
        end else begin
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = S_MOVE_RD;
        end
      end
      S_INS_WR: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (resp_ready) begin
          count_nxt = count_new;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    ins_r     <= ins_nxt;
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    ptr_r     <= ptr_nxt;
    value_r   <= value_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  always_comb begin
    if (!op_r) begin
      count_new = count_r;
    end else if (ins_r) begin
      count_new = count_r + CW'(1);
    end else begin
      count_new = count_r - CW'(1);
    end
  end

  assign cmd_ready          = (state_r == S_IDLE);
  assign resp_valid         = (state_r == S_RESP);
  assign resp.status        = status_r;
  assign resp.count         = ple_pkg::COUNT_W'(count_new);
  assign resp.removed_value = removed_r;

  assign ram_re    = (state_r == S_DEL_RD) || (state_r == S_MOVE_RD);
  assign ram_raddr = (state_r == S_DEL_RD) ? idx_r : ptr_r;
  assign ram_we    = (state_r == S_MOVE_WR) || (state_r == S_INS_WR);
  assign ram_wdata = (state_r == S_INS_WR) ? value_r : ram_rdata;
  assign ram_waddr = (state_r == S_INS_WR) ? idx_r :
                     (ins_r ? ptr_r + AW'(1) : ptr_r - AW'(1));

  `PLE_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "element count beyond depth")
  `PLE_ASSERT_IMPL(a_write_in_list, ram_we, CW'(ram_waddr) <= count_r,
    "list write beyond the end of the list")
  `PLE_ASSERT(a_insert_grows,
    (resp_valid && resp_ready && op_r && ins_r) |=> (count_r == $past(count_r) + CW'(1)),
    "successful insert did not grow the list")

endmodule

// ===== sv/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list of signed 32-bit values with front, back and
// positional insert and delete; one status transfer per command.
//
//   channel | dir | tdata fields (lsb first)
//   in_     | in  | cmd[2:0], value[34:3], position[39:35]
//   out_    | out | status[1:0], count[6:2], removed_value[38:7], zero[39]
//
// An insert at index i shifts the elements from the back down to i up by one,
// then writes the value; a delete at i captures that element, then shifts each
// later one down by one. Each moved element is read, then written on the list
// RAM. in_tready stays low until the result is loaded into the output register;
// a stalled result holds there while the next command runs. Reset clears the
// count, state and output valid only; RAM contents need no clearing.
// ----------------------------------------------------------------------------
`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd, value, position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status, count, removed_value, zero pad
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                       resp_valid;
  logic                       resp_ready;
  ple_pkg::resp_t             resp;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ple_pkg::DATA_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [ple_pkg::DATA_W-1:0] ram_rdata;

  logic                       out_valid_r;
  ple_pkg::resp_t             out_data_r;

  ple_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (in_tvalid),
    .cmd_ready  (in_tready),
    .cmd        (in_tdata[2:0]),
    .value      (in_tdata[34:3]),
    .position   (in_tdata[39:35]),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  ple_ram #(
    .WIDTH (ple_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Load a result when the output register is empty or its transfer completes
  assign resp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_ready) begin
      out_valid_r <= resp_valid;
    end
    if (resp_ready && resp_valid) begin
      out_data_r <= resp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.removed_value, out_data_r.count, out_data_r.status};

  `PLE_ASSERT_IMPL(a_removed_only_ok,
    out_tvalid && out_data_r.status != ple_pkg::ST_OK,
    out_data_r.removed_value == '0,
    "removed value on a failed command")

endmodule
